// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files of the sphere point block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that ante implies cons in the same cycle.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: label");

// Check that ante implies cons in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: label");

`endif

// ===== src/fsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg
// Widths, constants and the arctangent table of the sphere point pipeline.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int INDEX_BITS = 16;
  localparam int COUNT_BITS = INDEX_BITS + 1;
  localparam int A_BITS     = INDEX_BITS + 2;
  localparam int FRAC_SHIFT = 30 - INDEX_BITS;
  localparam int PROD_BITS  = 2 * INDEX_BITS + 4;
  localparam int RAD_BITS   = 64;
  localparam int ROOT_BITS  = 32;
  localparam int SQRT_STAGES = 32;
  localparam int CORDIC_STAGES = 32;
  localparam int XY_BITS    = 36;
  localparam int Z_BITS     = 34;
  localparam int ROUND_SHIFT = 32 - ANGLE_BITS;

  localparam logic [31:0] HALF_PHIR_LO = 32'hBFA53E0B;
  localparam logic [31:0] HALF_PHIR_HI = 32'h4F1BBCDC;

  // Register byte addresses
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;

  localparam logic [31:0] ATAN_TURN [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // Side data that rides alongside the square root and CORDIC pipelines
  typedef struct packed {
    logic signed [A_BITS-1:0] a;
    logic                     err;
    logic [ANGLE_BITS-1:0]    lon;
  } side_t;

endpackage

// ===== src/fsp_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module fsp_sqrt
  import fsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_BITS-1:0]  radicand,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] root
);

  logic                vld [SQRT_STAGES+1];
  logic [RAD_BITS-1:0] rem [SQRT_STAGES+1];
  logic [RAD_BITS-1:0] res [SQRT_STAGES+1];

  assign vld[0] = in_valid;
  assign rem[0] = radicand;
  assign res[0] = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [RAD_BITS-1:0] BIT = RAD_BITS'(1) << (RAD_BITS - 2 - 2 * k);
    logic [RAD_BITS-1:0] trial;
    assign trial = res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rem[k] >= trial) begin
        rem[k+1] <= rem[k] - trial;
        res[k+1] <= (res[k] >> 1) + BIT;
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= res[k] >> 1;
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES];
  assign root      = res[SQRT_STAGES][ROOT_BITS-1:0];

endmodule

// ===== src/fsp_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_cordic
// Pipelined vectoring CORDIC: angle of (x, y) in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module fsp_cordic
  import fsp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [A_BITS-1:0]    a,
  input  logic [ROOT_BITS-1:0]        b,
  output logic                        out_valid,
  output logic signed [Z_BITS-1:0]    angle
);

  logic                      vld [CORDIC_STAGES+1];
  logic signed [XY_BITS-1:0] x   [CORDIC_STAGES+1];
  logic signed [XY_BITS-1:0] y   [CORDIC_STAGES+1];
  logic signed [Z_BITS-1:0]  z   [CORDIC_STAGES+1];
  logic signed [XY_BITS-1:0] a_s;
  logic signed [XY_BITS-1:0] b_s;

  assign a_s = XY_BITS'(a) <<< FRAC_SHIFT;
  assign b_s = $signed({{(XY_BITS-ROOT_BITS){1'b0}}, b});

  // Turn by a quarter first when a is negative
  always_comb begin
    vld[0] = in_valid;
    if (a >= 0) begin
      x[0] = a_s;
      y[0] = b_s;
      z[0] = '0;
    end else begin
      x[0] = b_s;
      y[0] = -a_s;
      z[0] = Z_BITS'(64'sd1 <<< 30);
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [Z_BITS-1:0] step;
    assign step = $signed({{(Z_BITS-32){1'b0}}, ATAN_TURN[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (y[k] > 0) begin
        x[k+1] <= x[k] + (y[k] >>> k);
        y[k+1] <= y[k] - (x[k] >>> k);
        z[k+1] <= z[k] + step;
      end else begin
        x[k+1] <= x[k] - (y[k] >>> k);
        y[k+1] <= y[k] + (x[k] >>> k);
        z[k+1] <= z[k] - step;
      end
    end
  end

  assign out_valid = vld[CORDIC_STAGES];
  assign angle     = z[CORDIC_STAGES];

endmodule

// ===== src/fibonacci_sphere_point_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibonacci_sphere_point_top
// Point i of an n-point Fibonacci sphere lattice as two binary angles.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy stays low.
// Depth is set by the 32-stage square root and the 32-stage CORDIC.
// Reset clears all valid bits and sets point_count to 1.
// The receiver cannot stall, so results leave on a fixed schedule.
`include "assert_macros.svh"

module fibonacci_sphere_point_top
  import fsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_BITS-1:0] point_index,
  output logic                  done,
  output logic [ANGLE_BITS-1:0] colatitude,
  output logic [ANGLE_BITS-1:0] longitude,
  output logic                  index_error
);

  localparam int SIDE_DEPTH = SQRT_STAGES + CORDIC_STAGES;

  logic [COUNT_BITS-1:0] point_count;

  // Stage 1: capture index and count
  logic                  s1_valid;
  logic [INDEX_BITS-1:0] s1_idx;
  logic [COUNT_BITS-1:0] s1_n;

  // Stage 2: a = n - 2i - 1 and the two factors of n^2 - a^2
  logic                     s2_valid;
  logic signed [A_BITS-1:0] s2_a;
  logic [COUNT_BITS-1:0]    s2_f1;
  logic [A_BITS:0]          s2_f2;
  logic                     s2_err;

  // Stage 3: products
  logic                       s3_valid;
  logic signed [A_BITS-1:0]   s3_a;
  logic                       s3_err;
  logic [PROD_BITS-1:0]       s3_prod;
  logic signed [A_BITS+32:0]  s3_lp_lo;
  logic signed [A_BITS+32:0]  s3_lp_hi;
  logic signed [A_BITS-1:0]   neg_a;

  // Stage 4: longitude done, radicand ready
  logic                s4_valid;
  logic [RAD_BITS-1:0] s4_rad;
  logic [63:0]         lon_sum;
  logic [63:0]         lon_rnd;

  side_t side [SIDE_DEPTH+1];

  logic                     sq_valid;
  logic [ROOT_BITS-1:0]     sq_root;
  logic                     cd_valid;
  logic signed [Z_BITS-1:0] cd_angle;
  logic signed [Z_BITS-1:0] z_clamp;
  logic [Z_BITS-1:0]        z_rnd;
  logic                     accept;

  assign accept = start && !busy;
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration port: write on the access phase, reads return the count
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_BITS'(1);
    end else if (psel && penable && pwrite && paddr == ADDR_POINT_COUNT) begin
      point_count <= pwdata[COUNT_BITS-1:0];
    end
  end

  assign prdata = (paddr == ADDR_POINT_COUNT) ? {{(32-COUNT_BITS){1'b0}}, point_count} : '0;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  assign neg_a = -s2_a;

  always_ff @(posedge clk) begin
    // Stage 1: snapshot the count with the transaction
    s1_idx <= point_index;
    s1_n   <= point_count;
    // Stage 2
    s2_a   <= $signed({1'b0, s1_n}) - $signed({1'b0, s1_idx, 1'b1});
    s2_f1  <= {s1_idx, 1'b1};
    s2_f2  <= {1'b0, s1_n, 1'b0} - {2'b00, s1_idx, 1'b1};
    s2_err <= {1'b0, s1_idx} >= s1_n;
    // Stage 3: (2i+1)(2n-2i-1) and -a times phir/2 split in halves
    s3_a     <= s2_a;
    s3_err   <= s2_err;
    s3_prod  <= PROD_BITS'(s2_f1) * PROD_BITS'(s2_f2);
    s3_lp_lo <= neg_a * $signed({1'b0, HALF_PHIR_LO});
    s3_lp_hi <= neg_a * $signed({1'b0, HALF_PHIR_HI});
    // Stage 4
    s4_rad      <= RAD_BITS'(s3_prod) << (2 * FRAC_SHIFT);
    side[0].a   <= s3_a;
    side[0].err <= s3_err;
    side[0].lon <= lon_rnd[63 -: ANGLE_BITS];
  end

  // Product modulo 2^64, then round half up to the angle width
  assign lon_sum = 64'(s3_lp_lo) + {s3_lp_hi[31:0], 32'h0};
  assign lon_rnd = lon_sum + (64'd1 << (64 - ANGLE_BITS - 1));

  // Advance the side data in step with the two pipelines
  for (genvar j = 1; j <= SIDE_DEPTH; j++) begin : g_side
    always_ff @(posedge clk) begin
      side[j] <= side[j-1];
    end
  end

  fsp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_valid),
    .radicand  (s4_rad),
    .out_valid (sq_valid),
    .root      (sq_root)
  );

  fsp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .a         (side[SQRT_STAGES].a),
    .b         (sq_root),
    .out_valid (cd_valid),
    .angle     (cd_angle)
  );

  // Clamp the angle to [0, half turn], then round half up
  always_comb begin
    priority if (cd_angle < 0) begin
      z_clamp = '0;
    end else if (cd_angle > (Z_BITS'(64'sd1 <<< 31))) begin
      z_clamp = Z_BITS'(64'sd1 <<< 31);
    end else begin
      z_clamp = cd_angle;
    end
  end

  assign z_rnd = Z_BITS'(z_clamp) + (Z_BITS'(1) << (ROUND_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cd_valid;
    end
  end

  // Drop the angles on an out-of-range index
  always_ff @(posedge clk) begin
    index_error <= side[SIDE_DEPTH].err;
    if (side[SIDE_DEPTH].err) begin
      colatitude <= '0;
      longitude  <= '0;
    end else begin
      colatitude <= z_rnd[ROUND_SHIFT +: ANGLE_BITS];
      longitude  <= side[SIDE_DEPTH].lon;
    end
  end

  `ASSERT_IMPLY(a_err_zero, done && index_error, colatitude == '0 && longitude == '0)
  `ASSERT_IMPLY(a_colat_range, done, colatitude <= (ANGLE_BITS'(1) << (ANGLE_BITS - 1)))
  `ASSERT_NEXT(a_enter, start && !busy, s1_valid)
  `ASSERT_IMPLY(a_sqrt_cordic, sq_valid, $past(s4_valid, SQRT_STAGES))

endmodule

// ===== bench/fibonacci_sphere_point_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fibonacci_sphere_point_top_tb
// Self-checking bench for the Fibonacci sphere lattice point block.
// Each accepted point index is predicted in an integer model of the
// square-root/CORDIC colatitude and the golden-ratio longitude. Results are
// matched in order against that model. The point count register is swept
// through several values over the APB port, the extremes among them.
// ----------------------------------------------------------------------------
module fibonacci_sphere_point_top_tb
  import fsp_pkg::*;
();

  // Expected angles of one lattice point
  typedef struct {
    logic [ANGLE_BITS-1:0] colat;
    logic [ANGLE_BITS-1:0] lon;
    logic                  err;
  } lattice_point_t;

  // Predicts lattice points and holds the ones still in flight
  class lattice_scoreboard;
    logic [COUNT_BITS-1:0] count;
    lattice_point_t        in_flight[$];
    int                    errors;

    function new();
      count  = 1;
      errors = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // atan2(b, a) by vectoring CORDIC, as a binary angle
    function logic [ANGLE_BITS-1:0] colatitude_of(longint a, logic [63:0] prod);
      longint x, y, z, dx, dy;
      logic [63:0] r;
      if (a >= 0) begin
        x = a <<< FRAC_SHIFT;
        y = longint'(isqrt(prod << (2 * FRAC_SHIFT)));
        z = 0;
      end else begin
        x = longint'(isqrt(prod << (2 * FRAC_SHIFT)));
        y = -(a <<< FRAC_SHIFT);
        z = longint'(1) << 30;
      end
      for (int k = 0; k < CORDIC_STAGES; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y > 0) begin
          x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN[k]);
        end else begin
          x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN[k]);
        end
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 31)) z = longint'(1) << 31;
      r = 64'(z);
      r = (r + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      return r[ANGLE_BITS-1:0];
    endfunction

    function logic [ANGLE_BITS-1:0] longitude_of(longint a);
      logic [63:0] p;
      p = (64'd0 - 64'(a)) * {HALF_PHIR_HI, HALF_PHIR_LO};
      p = (p + (64'd1 << (63 - ANGLE_BITS))) >> (64 - ANGLE_BITS);
      return p[ANGLE_BITS-1:0];
    endfunction

    // Note an accepted index and queue its expected point
    function void note_index(logic [INDEX_BITS-1:0] idx);
      lattice_point_t e;
      longint         n, i, a;
      logic [63:0]    prod;
      n = longint'(count);
      i = longint'(idx);
      if (i >= n) begin
        e.colat = 0; e.lon = 0; e.err = 1'b1;
      end else begin
        a    = n - 2 * i - 1;
        prod = 64'(2 * i + 1) * 64'(2 * n - 2 * i - 1);
        e.colat = colatitude_of(a, prod);
        e.lon   = longitude_of(a);
        e.err   = 1'b0;
      end
      in_flight.push_back(e);
    endfunction

    // Check one result strobe against the oldest expected point
    function void check_point(logic [ANGLE_BITS-1:0] c, logic [ANGLE_BITS-1:0] l,
                              logic e);
      lattice_point_t x;
      if (in_flight.size() == 0) begin
        $display("%0t: unexpected result colat=%0d lon=%0d err=%0d", $time, c, l, e);
        errors++;
        return;
      end
      x = in_flight.pop_front();
      if (c !== x.colat) begin
        $display("%0t: colatitude expected %0d actual %0d", $time, x.colat, c);
        errors++;
      end
      if (l !== x.lon) begin
        $display("%0t: longitude expected %0d actual %0d", $time, x.lon, l);
        errors++;
      end
      if (e !== x.err) begin
        $display("%0t: index_error expected %0d actual %0d", $time, x.err, e);
        errors++;
      end
    endfunction
  endclass

  localparam int PIPE_WAIT = 80;   // longer than the pipeline latency

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [INDEX_BITS-1:0] point_index = '0;
  logic                  done;
  logic [ANGLE_BITS-1:0] colatitude;
  logic [ANGLE_BITS-1:0] longitude;
  logic                  index_error;

  lattice_scoreboard board = new();

  fibonacci_sphere_point_top dut (.*);

  always #5 clk = ~clk;

  // Watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_index(point_index);
      if (done) board.check_point(colatitude, longitude, index_error);
    end
  end

  // Write the point count, then read it back; only called while idle
  task automatic set_point_count(logic [COUNT_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_POINT_COUNT; pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.count = value;
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COUNT_BITS-1:0] !== value) begin
      $display("%0t: point_count readback expected %0d actual %0d", $time, value,
               prdata[COUNT_BITS-1:0]);
      board.errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Present one index, hold it until taken, then idle for the given gap
  task automatic send_index(logic [INDEX_BITS-1:0] idx, int gap);
    @(negedge clk);
    start <= 1'b1;
    point_index <= idx;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      point_index <= INDEX_BITS'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.in_flight.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  initial begin
    logic [COUNT_BITS-1:0] counts[$];
    logic [COUNT_BITS-1:0] n;
    logic [INDEX_BITS-1:0] idx;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count of one: only index zero is valid
    send_index(0, 0);
    send_index(1, 0);
    send_index('1, 1);
    drain();

    // Full lattice: poles, equator and the last index
    set_point_count(COUNT_BITS'(65536));
    send_index(16'd0, 0);     send_index(16'd1, 0);
    send_index(16'd32767, 0); send_index(16'd32768, 0);
    send_index(16'd65534, 2); send_index(16'd65535, 0);
    send_index(16'h5555, 0);  send_index(16'hAAAA, 0);
    drain();

    // Zero count: everything is an error
    set_point_count('0);
    send_index(16'd0, 0);
    send_index(16'hFFFF, 0);
    drain();

    // Count above the index range: every index is valid
    set_point_count('1);
    send_index(16'd0, 0);
    send_index(16'hFFFF, 0);
    drain();

    // A small even count, with the boundary index
    set_point_count(COUNT_BITS'(2));
    send_index(16'd0, 0); send_index(16'd1, 0); send_index(16'd2, 0);
    drain();

    // Random phases over a sweep of counts
    counts = '{COUNT_BITS'(65536), COUNT_BITS'(1), COUNT_BITS'(3), COUNT_BITS'(1000),
               '1, '0, COUNT_BITS'(65535), COUNT_BITS'(32768)};
    repeat (2) counts.push_back(COUNT_BITS'($urandom_range(1, 131071)));
    foreach (counts[p]) begin
      n = counts[p];
      set_point_count(n);
      repeat (170) begin
        if (n != 0 && $urandom_range(0, 99) < 85)
          idx = INDEX_BITS'($urandom_range(0, (n > 65536) ? 65535 : n - 1));
        else
          idx = INDEX_BITS'($urandom);
        send_index(idx, draw_gap());
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fsp_pkg.sv
src/fsp_sqrt.sv
src/fsp_cordic.sv
src/fibonacci_sphere_point_top.sv
bench/fibonacci_sphere_point_top_tb.sv
